[rtl/core/u8slice_pkg.sv]
// Shared types and constants of the UTF-8 substring slicer.
package u8slice_pkg;

   // Strings are cut off after this many bytes; the byte counter holds there.
   localparam logic [15:0] MAX_BYTES = 16'd65535;

   // A continuation byte matches CONT_CODE under LEAD_MASK; every other byte leads.
   localparam logic [7:0] LEAD_MASK = 8'hC0;
   localparam logic [7:0] CONT_CODE = 8'h80;

   // Kind of the located substring.
   typedef enum logic [1:0] {
      KIND_NA       = 2'd0,
      KIND_ORIGINAL = 2'd1,
      KIND_RANGE    = 2'd2
   } kind_type;

   // One input item as held in the input register.
   typedef struct packed {
      logic [7:0]         data_byte;
      logic               byte_valid;
      logic               end_of_string;
      logic               string_missing;
      logic signed [31:0] start_index;
      logic signed [31:0] stop_index;
      logic               start_missing;
      logic               stop_missing;
      logic               utf8_mode;
   } item_type;

   // Scan state of the current string.
   typedef struct packed {
      logic [15:0] byte_count;
      logic [15:0] char_count;
      logic [15:0] first_offset;
      logic [15:0] end_offset;
      logic        first_seen;
      logic        end_seen;
   } scan_type;

   // Clamp a requested start position to at least one.
   function automatic logic signed [31:0] clamp_start(input logic signed [31:0] start);
      clamp_start = (start < 32'sd1) ? 32'sd1 : start;
   endfunction

endpackage

[rtl/core/u8slice_in_stage.sv]
// Input register of the slicer with its ready logic.
module u8slice_in_stage
   import u8slice_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     out_free,
   output item_type item,
   output logic     proc_fire
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // The held item moves on unless it ends a string and the result register is full.
   assign proc_fire = valid_ff && (!item_ff.end_of_string || out_free);
   assign req_ready = !valid_ff || proc_fire;
   assign item      = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded only on an accepted transfer.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

[rtl/core/u8slice_scan.sv]
// Byte and character counters that track where the substring begins and ends.
module u8slice_scan
   import u8slice_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  item_type item,
   input  logic     proc_fire,
   output scan_type scan_next
);

   scan_type           scan_ff;
   scan_type           scan_in;
   logic signed [31:0] start_c;
   logic [15:0]        char_inc;
   logic               lead;

   assign start_c  = clamp_start(item.start_index);
   assign lead     = (item.data_byte & LEAD_MASK) != CONT_CODE;
   assign char_inc = scan_ff.char_count + 16'd1;

   // State after the held item has been scanned; the result is taken from this.
   always_comb begin
      scan_next = scan_ff;
      if (item.byte_valid && (scan_ff.byte_count < MAX_BYTES)) begin
         if (item.utf8_mode && !scan_ff.end_seen && lead) begin
            scan_next.char_count = char_inc;
            if ($signed({16'd0, char_inc}) == start_c && !scan_ff.first_seen) begin
               scan_next.first_offset = scan_ff.byte_count;
               scan_next.first_seen   = 1'b1;
            end
            if ($signed({16'd0, char_inc}) > item.stop_index) begin
               scan_next.end_offset = scan_ff.byte_count;
               scan_next.end_seen   = 1'b1;
            end
         end
         scan_next.byte_count = scan_ff.byte_count + 16'd1;
      end
   end

   // The state clears after the item that ends a string.
   always_comb begin
      scan_in = scan_ff;
      if (proc_fire) begin
         scan_in = item.end_of_string ? '0 : scan_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= '0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   // The byte counter never passes the string bound.
   assert property (@(posedge clock) disable iff (reset)
      scan_ff.byte_count <= MAX_BYTES)
      else $error("byte counter passed the string bound");

   // Characters are counted only on bytes, so there are never more of them.
   assert property (@(posedge clock) disable iff (reset)
      scan_ff.char_count <= scan_ff.byte_count)
      else $error("character count exceeds byte count");

   // A finished string leaves a clean state behind.
   assert property (@(posedge clock) disable iff (reset)
      proc_fire && item.end_of_string |=> scan_ff == '0)
      else $error("scan state not cleared after end of string");

endmodule

[rtl/core/u8slice_result.sv]
// Result computation of a finished string and the output register.
module u8slice_result
   import u8slice_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  item_type    item,
   input  scan_type    scan_next,
   input  logic        proc_fire,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_slice_offset,
   output logic [15:0] rsp_slice_length,
   output logic [1:0]  rsp_slice_kind
);

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [15:0]        offset_ff;
   logic [15:0]        length_ff;
   kind_type           kind_ff;
   logic [15:0]        offset_in;
   logic [15:0]        length_in;
   kind_type           kind_in;
   logic               load;
   logic signed [31:0] start_c;
   logic signed [31:0] size;
   logic signed [31:0] b_first;
   logic signed [31:0] b_last;
   logic signed [31:0] b_len;
   logic [15:0]        u_last;
   logic [15:0]        u_first;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign load     = proc_fire && item.end_of_string;
   assign start_c  = clamp_start(item.start_index);
   assign size     = $signed({16'd0, scan_next.byte_count});

   // Byte mode: positions are byte offsets, the end clipped to the string size.
   always_comb begin
      b_first = start_c - 32'sd1;
      if (item.stop_index < 32'sd1) begin
         b_last = 32'sd0;
      end else if (item.stop_index > size) begin
         b_last = size;
      end else begin
         b_last = item.stop_index;
      end
      b_len = b_last - b_first;
   end

   // Character mode: the end is the first lead byte past stop, or the string end.
   always_comb begin
      u_first = scan_next.first_offset;
      u_last  = scan_next.end_seen ? scan_next.end_offset : scan_next.byte_count;
      if (item.stop_index >= $signed({16'd0, scan_next.char_count})) begin
         u_last = scan_next.byte_count;
      end
      if (u_last < u_first) begin
         u_last = u_first;
      end
   end

   // Pick the result for the ending item.
   always_comb begin
      offset_in = 16'd0;
      length_in = 16'd0;
      kind_in   = KIND_RANGE;
      if (item.string_missing || item.start_missing || item.stop_missing) begin
         kind_in = KIND_NA;
      end else if (!item.utf8_mode) begin
         if (!(item.stop_index < start_c || start_c > size || b_first >= b_last)) begin
            offset_in = b_first[15:0];
            length_in = b_len[15:0];
            kind_in   = (b_first == 32'sd0 && b_last == size) ? KIND_ORIGINAL : KIND_RANGE;
         end
      end else begin
         if (!(item.stop_index < start_c || !scan_next.first_seen)) begin
            offset_in = u_first;
            length_in = u_last - u_first;
            kind_in   = (u_first == 16'd0 && u_last == scan_next.byte_count)
                        ? KIND_ORIGINAL : KIND_RANGE;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         offset_ff <= offset_in;
         length_ff <= length_in;
         kind_ff   <= kind_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slice_offset = offset_ff;
   assign rsp_slice_length = length_ff;
   assign rsp_slice_kind   = kind_ff;

   // A missing result carries no offset or length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_NA |-> offset_ff == 16'd0 && length_ff == 16'd0)
      else $error("NA result with non-zero fields");

   // The whole original string always starts at offset zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && kind_ff == KIND_ORIGINAL |-> offset_ff == 16'd0)
      else $error("original string result with non-zero offset");

endmodule

[rtl/core/utf8_substring_slicer.sv]
// Top level of the streaming UTF-8 substring slicer.
// Usage: the bytes of one string enter on the req_ channel, one transfer per byte,
// with the start and stop positions, the missing flags and the mode on every transfer.
// The transfer with req_end_of_string set closes the string; an empty string is a
// single transfer with req_byte_valid low and req_end_of_string high.
// For each closed string one result transfer leaves on the rsp_ channel: byte offset,
// byte length and kind (NA, whole original string or byte range). Other transfers
// give no result.
// The ending transfer is held in the input register; its result is then presented
// from the result register. Throughput: one transfer per cycle while no ending
// transfer waits on a full result register; each byte needs one counter update and
// one compare against the clamped positions between the input and result registers.
// Reset clears the counters, the input register and the result register.
// When the receiver stalls, the result register holds its transfer; bytes of the
// next string are still accepted, but the next ending transfer waits in the input
// register and the req_ channel stalls behind it until the result is taken.
module utf8_substring_slicer
   import u8slice_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_byte_valid,
   input  logic               req_end_of_string,
   input  logic               req_string_missing,
   input  logic signed [31:0] req_start_index,
   input  logic signed [31:0] req_stop_index,
   input  logic               req_start_missing,
   input  logic               req_stop_missing,
   input  logic               req_utf8_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [15:0]        rsp_slice_offset,
   output logic [15:0]        rsp_slice_length,
   output logic [1:0]         rsp_slice_kind
);

   item_type req_item;
   item_type item;
   scan_type scan_next;
   logic     proc_fire;
   logic     out_free;

   // Gather the payload ports into one item.
   always_comb begin
      req_item.data_byte      = req_data_byte;
      req_item.byte_valid     = req_byte_valid;
      req_item.end_of_string  = req_end_of_string;
      req_item.string_missing = req_string_missing;
      req_item.start_index    = req_start_index;
      req_item.stop_index     = req_stop_index;
      req_item.start_missing  = req_start_missing;
      req_item.stop_missing   = req_stop_missing;
      req_item.utf8_mode      = req_utf8_mode;
   end

   u8slice_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_free  (out_free),
      .item      (item),
      .proc_fire (proc_fire)
   );

   u8slice_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .proc_fire (proc_fire),
      .scan_next (scan_next)
   );

   u8slice_result u_result (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .scan_next        (scan_next),
      .proc_fire        (proc_fire),
      .out_free         (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_slice_offset (rsp_slice_offset),
      .rsp_slice_length (rsp_slice_length),
      .rsp_slice_kind   (rsp_slice_kind)
   );

endmodule

[verif/utf8_slice_checker.sv]
// Checker of the UTF-8 substring slicer: follows both channels, predicts each slice and compares.
`timescale 1ns / 1ps

module utf8_slice_checker
   import u8slice_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_data_byte,
   input  logic               req_byte_valid,
   input  logic               req_end_of_string,
   input  logic               req_string_missing,
   input  logic signed [31:0] req_start_index,
   input  logic signed [31:0] req_stop_index,
   input  logic               req_start_missing,
   input  logic               req_stop_missing,
   input  logic               req_utf8_mode,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [15:0]        rsp_slice_offset,
   input  logic [15:0]        rsp_slice_length,
   input  logic [1:0]         rsp_slice_kind,
   output int                 fail_count,
   output int                 pending_count,
   output int                 checked_count
);

   typedef struct packed {
      logic [15:0] offset;
      logic [15:0] length;
      kind_type    kind;
   } slice_type;

   // Slices still owed by the block, oldest first.
   slice_type awaited_slices[$];

   // Shadow of the scan state of the string in flight.
   int unsigned bytes_seen;
   int unsigned chars_seen;
   int unsigned start_offset;
   int unsigned stop_offset;
   bit          start_found;
   bit          stop_found;

   function automatic void clear_scan();
      bytes_seen   = 0;
      chars_seen   = 0;
      start_offset = 0;
      stop_offset  = 0;
      start_found  = 1'b0;
      stop_found   = 1'b0;
   endfunction

   function automatic slice_type make_slice(input longint first, input longint last,
                                            input kind_type kind);
      slice_type s;
      s.offset = 16'(first);
      s.length = 16'(last - first);
      s.kind   = kind;
      return s;
   endfunction

   // Advance the scan by one transfer and, on the closing transfer, work out the slice.
   function automatic void locate_slice(input item_type it);
      longint    lo_pos;
      longint    hi_pos;
      longint    size;
      longint    first;
      longint    last;
      slice_type s;
      lo_pos = longint'($signed(it.start_index));
      hi_pos = longint'($signed(it.stop_index));
      if (lo_pos < 1) begin
         lo_pos = 1;
      end

      // Bytes past the limit are neither counted nor scanned.
      if (it.byte_valid && bytes_seen < MAX_BYTES) begin
         if (it.utf8_mode && !stop_found && ((it.data_byte & LEAD_MASK) != CONT_CODE)) begin
            chars_seen++;
            if (longint'(chars_seen) == lo_pos && !start_found) begin
               start_offset = bytes_seen;
               start_found  = 1'b1;
            end
            if (longint'(chars_seen) > hi_pos) begin
               stop_offset = bytes_seen;
               stop_found  = 1'b1;
            end
         end
         bytes_seen++;
      end

      if (!it.end_of_string) begin
         return;
      end

      size = longint'(bytes_seen);
      if (it.string_missing || it.start_missing || it.stop_missing) begin
         s = make_slice(0, 0, KIND_NA);
      end else if (!it.utf8_mode) begin
         // Byte positions.
         if (hi_pos < lo_pos || lo_pos > size) begin
            s = make_slice(0, 0, KIND_RANGE);
         end else begin
            first = lo_pos - 1;
            last  = (hi_pos < 1) ? 0 : hi_pos;
            if (last > size) begin
               last = size;
            end
            if (first >= last) begin
               s = make_slice(0, 0, KIND_RANGE);
            end else begin
               s = make_slice(first, last,
                              (first == 0 && last == size) ? KIND_ORIGINAL : KIND_RANGE);
            end
         end
      end else begin
         // Character positions, from the offsets caught during the scan.
         if (hi_pos < lo_pos || !start_found) begin
            s = make_slice(0, 0, KIND_RANGE);
         end else begin
            first = longint'(start_offset);
            last  = stop_found ? longint'(stop_offset) : size;
            if (hi_pos >= longint'(chars_seen)) begin
               last = size;
            end
            if (last < first) begin
               last = first;
            end
            s = make_slice(first, last,
                           (first == 0 && last == size) ? KIND_ORIGINAL : KIND_RANGE);
         end
      end
      awaited_slices.push_back(s);
      clear_scan();
   endfunction

   // Both channels are sampled at the rising edge; a result is checked before the
   // request of the same edge is scanned.
   always @(posedge clock) begin : watch_channels
      item_type  it;
      slice_type want;
      if (reset) begin
         clear_scan();
         awaited_slices.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_slices.size() == 0) begin
               $error("Result transfer with no slice awaited: offset %0d, length %0d, kind %0d",
                      rsp_slice_offset, rsp_slice_length, rsp_slice_kind);
               fail_count++;
            end else begin
               want = awaited_slices.pop_front();
               checked_count++;
               if (rsp_slice_offset !== want.offset) begin
                  $error("slice_offset: expected %0d, got %0d", want.offset, rsp_slice_offset);
                  fail_count++;
               end
               if (rsp_slice_length !== want.length) begin
                  $error("slice_length: expected %0d, got %0d", want.length, rsp_slice_length);
                  fail_count++;
               end
               if (rsp_slice_kind !== want.kind) begin
                  $error("slice_kind: expected %0d, got %0d", want.kind, rsp_slice_kind);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            it.data_byte      = req_data_byte;
            it.byte_valid     = req_byte_valid;
            it.end_of_string  = req_end_of_string;
            it.string_missing = req_string_missing;
            it.start_index    = req_start_index;
            it.stop_index     = req_stop_index;
            it.start_missing  = req_start_missing;
            it.stop_missing   = req_stop_missing;
            it.utf8_mode      = req_utf8_mode;
            locate_slice(it);
         end
      end
      pending_count = awaited_slices.size();
   end

endmodule

[verif/tb_utf8_substring_slicer.sv]
// Testbench top of the UTF-8 substring slicer: clock, reset, string stimulus and verdict.
`timescale 1ns / 1ps

module tb_utf8_substring_slicer;
   import u8slice_pkg::*;

   localparam int TOTAL_ITEMS = 1650;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_data_byte;
   logic               req_byte_valid;
   logic               req_end_of_string;
   logic               req_string_missing;
   logic signed [31:0] req_start_index;
   logic signed [31:0] req_stop_index;
   logic               req_start_missing;
   logic               req_stop_missing;
   logic               req_utf8_mode;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [15:0]        rsp_slice_offset;
   logic [15:0]        rsp_slice_length;
   logic [1:0]         rsp_slice_kind;

   int fail_count;
   int pending_count;
   int checked_count;

   // Percentages of idle cycles on the sending and receiving sides.
   int gap_pct   = 9;
   int stall_pct = 9;
   int items_sent;
   int strings_sent;

   // Bytes of the string about to be sent.
   logic [7:0] text_bytes[$];

   utf8_substring_slicer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_string  (req_end_of_string),
      .req_string_missing (req_string_missing),
      .req_start_index    (req_start_index),
      .req_stop_index     (req_stop_index),
      .req_start_missing  (req_start_missing),
      .req_stop_missing   (req_stop_missing),
      .req_utf8_mode      (req_utf8_mode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slice_offset   (rsp_slice_offset),
      .rsp_slice_length   (rsp_slice_length),
      .rsp_slice_kind     (rsp_slice_kind)
   );

   utf8_slice_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_string  (req_end_of_string),
      .req_string_missing (req_string_missing),
      .req_start_index    (req_start_index),
      .req_stop_index     (req_stop_index),
      .req_start_missing  (req_start_missing),
      .req_stop_missing   (req_stop_missing),
      .req_utf8_mode      (req_utf8_mode),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_slice_offset   (rsp_slice_offset),
      .rsp_slice_length   (rsp_slice_length),
      .rsp_slice_kind     (rsp_slice_kind),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .checked_count      (checked_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // The receiver stalls at random; it is changed only at the falling edge.
   always @(negedge clock) begin
      rsp_ready = !reset && ($urandom_range(99) >= stall_pct);
   end

   // A position anywhere in the legal signed range.
   function automatic int any_index();
      int v;
      v = $urandom;
      if (v == int'(32'h8000_0000)) begin
         v = v + 1;
      end
      return v;
   endfunction

   // Mostly positions near the string, now and then far out or at the extremes.
   function automatic int pick_index(input int chars);
      int roll;
      roll = $urandom_range(99);
      if (roll < 80) begin
         return $urandom_range(chars + 3) - 2;
      end else if (roll < 90) begin
         return any_index();
      end
      case ($urandom_range(3))
         0:       return -2147483647;
         1:       return 2147483647;
         2:       return 0;
         default: return 1;
      endcase
   endfunction

   // Fill the string with well-formed characters, or with raw bytes when noisy.
   task automatic fill_text(input int chars, input bit noisy);
      int width;
      text_bytes.delete();
      for (int c = 0; c < chars; c++) begin
         if (noisy) begin
            text_bytes.push_back(8'($urandom));
         end else begin
            width = $urandom_range(1, 4);
            case (width)
               1:       text_bytes.push_back(8'($urandom_range(127)));
               2:       text_bytes.push_back(8'hC0 | 8'($urandom_range(31)));
               3:       text_bytes.push_back(8'hE0 | 8'($urandom_range(15)));
               default: text_bytes.push_back(8'hF0 | 8'($urandom_range(7)));
            endcase
            for (int k = 1; k < width; k++) begin
               text_bytes.push_back(8'h80 | 8'($urandom_range(63)));
            end
         end
      end
   endtask

   // One request transfer; called and returning at a falling edge.
   task automatic drive_item(input item_type it);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      {req_data_byte, req_byte_valid, req_end_of_string, req_string_missing,
       req_start_index, req_stop_index, req_start_missing, req_stop_missing,
       req_utf8_mode} = it;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   // A transfer without a byte; the missing flags are noise unless it closes the string.
   function automatic item_type base_item(input int start_pos, input int stop_pos,
                                          input bit utf8, input int wobble_pct);
      item_type it;
      it.data_byte     = 8'($urandom);
      it.byte_valid    = 1'b0;
      it.end_of_string = 1'b0;
      {it.string_missing, it.start_missing, it.stop_missing} = 3'($urandom);
      it.start_index   = start_pos;
      it.stop_index    = stop_pos;
      it.utf8_mode     = utf8;
      // Positions and mode may move while the string is in flight.
      if ($urandom_range(99) < wobble_pct) begin
         it.start_index = $urandom_range(6) - 1;
         it.stop_index  = $urandom_range(8) - 1;
         it.utf8_mode   = 1'($urandom);
      end
      return it;
   endfunction

   // Send text_bytes as one string; missing is {string, start, stop}.
   task automatic send_string(input int start_pos, input int stop_pos, input bit utf8,
                              input bit [2:0] missing, input bit tail_byte,
                              input int hole_pct, input int wobble_pct);
      item_type it;
      int       n;
      bit       closed;
      n      = text_bytes.size();
      closed = 1'b0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < hole_pct) begin
            drive_item(base_item(start_pos, stop_pos, utf8, wobble_pct));
         end
         it            = base_item(start_pos, stop_pos, utf8, wobble_pct);
         it.data_byte  = text_bytes[i];
         it.byte_valid = 1'b1;
         if (i == n - 1 && tail_byte) begin
            it.end_of_string = 1'b1;
            it.start_index   = start_pos;
            it.stop_index    = stop_pos;
            it.utf8_mode     = utf8;
            {it.string_missing, it.start_missing, it.stop_missing} = missing;
            closed = 1'b1;
         end
         drive_item(it);
      end
      // Closing transfer without a byte, which is also the whole of an empty string.
      if (!closed) begin
         it               = base_item(start_pos, stop_pos, utf8, 0);
         it.end_of_string = 1'b1;
         {it.string_missing, it.start_missing, it.stop_missing} = missing;
         drive_item(it);
      end
      strings_sent++;
   endtask

   // The sender holds off until every slice owed so far has been checked.
   task automatic drain_results();
      req_valid = 1'b0;
      wait (pending_count == 0);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int  chars;
      int  random_start;
      bit  utf8;
      bit  [2:0] missing;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_data_byte      = '0;
      req_byte_valid     = 1'b0;
      req_end_of_string  = 1'b0;
      req_string_missing = 1'b0;
      req_start_index    = '0;
      req_stop_index     = '0;
      req_start_missing  = 1'b0;
      req_stop_missing   = 1'b0;
      req_utf8_mode      = 1'b0;
      items_sent         = 0;
      strings_sent       = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed strings: empty strings, each missing flag, clamping, extremes and
      // an inverted range, in both modes.
      text_bytes.delete();
      send_string(1, 1, 1'b0, 3'b000, 1'b0, 0, 0);
      send_string(0, 5, 1'b1, 3'b000, 1'b0, 0, 0);
      text_bytes = {8'h61, 8'h62};
      send_string(1, 2, 1'b0, 3'b100, 1'b1, 0, 0);
      send_string(1, 2, 1'b1, 3'b010, 1'b1, 0, 0);
      send_string(1, 2, 1'b0, 3'b001, 1'b0, 0, 0);
      text_bytes = {8'h68, 8'h65, 8'h6C, 8'h6C, 8'h6F};
      send_string(-2147483647, 2147483647, 1'b0, 3'b000, 1'b1, 0, 0);
      text_bytes = {8'h61, 8'hC3, 8'hA9, 8'h62};
      send_string(2, 2, 1'b1, 3'b000, 1'b1, 50, 0);
      send_string(3, 2, 1'b1, 3'b000, 1'b1, 0, 0);
      text_bytes = {8'hFF, 8'h80};
      send_string(2147483647, -2147483647, 1'b0, 3'b000, 1'b1, 0, 50);
      drain_results();

      // Longer strings sent back to back: a whole string in byte mode, then a
      // character range inside a longer UTF-8 string.
      gap_pct   = 0;
      stall_pct = 0;
      text_bytes.delete();
      for (int i = 0; i < 120; i++) begin
         text_bytes.push_back(8'($urandom));
      end
      send_string(1, 120, 1'b0, 3'b000, 1'b1, 0, 0);
      fill_text(60, 1'b0);
      random_start = int'($urandom_range(1, 40));
      send_string(random_start, random_start + int'($urandom_range(30)), 1'b1, 3'b000,
                  1'b1, 0, 0);
      drain_results();

      // Random strings, mostly well-formed UTF-8, with a stretch free of idling.
      for (int s = 0; items_sent < TOTAL_ITEMS; s++) begin
         gap_pct   = (s >= 30 && s < 70) ? 0 : 9;
         stall_pct = gap_pct;
         chars     = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(12);
         fill_text(chars, $urandom_range(99) < 20);
         utf8    = 1'($urandom);
         missing = {$urandom_range(99) < 8, $urandom_range(99) < 8, $urandom_range(99) < 8};
         send_string(pick_index(chars), pick_index(chars), utf8, missing, 1'($urandom),
                     ($urandom_range(3) == 0) ? 15 : 0,
                     ($urandom_range(99) < 15) ? 20 : 0);
         if (s % 50 == 49) begin
            drain_results();
         end
      end

      // Let the last slices come out, then give the verdict.
      req_valid = 1'b0;
      wait (pending_count == 0);
      repeat (8) @(posedge clock);
      $display("Covered %0d strings, empty and long ones among them, in both modes;",
               strings_sent);
      $display("%0d slices checked against the prediction, %0d mismatches.",
               checked_count, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
